FILE: hdl/jtp_pkg.sv
// ----------------------------------------------------------------------------
// jtp_pkg: shared types and constants for the permutation stepper
// Sizes of the arrangement store, command codes and the control word
// that the sequencer sends to the rotating element store.
// ----------------------------------------------------------------------------
package jtp_pkg;

  localparam int MaxElements = 16;
  localparam int IdxW        = $clog2(MaxElements);
  localparam int CountW      = $clog2(MaxElements + 1);
  localparam int ValW        = 8;
  localparam int CmdW        = 2;
  localparam int PosW        = 4;

  localparam logic [CmdW-1:0] CmdLoad    = 2'd0;
  localparam logic [CmdW-1:0] CmdAdvance = 2'd1;
  localparam logic [CmdW-1:0] CmdRead    = 2'd2;

  localparam logic [CountW-1:0] CountReset = CountW'(MaxElements);

  typedef struct packed {
    logic            load;
    logic [IdxW-1:0] load_pos;
    logic [ValW-1:0] load_val;
    logic            shift;
    logic            swap;
    logic            flip;
  } ring_ctl_t;

endpackage

FILE: hdl/jtp_if.sv
// ----------------------------------------------------------------------------
// jtp_in_if / jtp_out_if: command and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface jtp_in_if;
  logic                      valid;
  logic                      ready;
  logic [jtp_pkg::CmdW-1:0]  command;
  logic [jtp_pkg::PosW-1:0]  position;
  logic [jtp_pkg::ValW-1:0]  element_value;

  modport source (output valid, output command, output position, output element_value,
                  input ready);
  modport sink   (input valid, input command, input position, input element_value,
                  output ready);
endinterface

interface jtp_out_if;
  logic                      valid;
  logic                      ready;
  logic [jtp_pkg::PosW-1:0]  out_position;
  logic [jtp_pkg::ValW-1:0]  out_value;
  logic                      faces_left;
  logic                      last_of_run;
  logic                      finished;

  modport source (output valid, output out_position, output out_value, output faces_left,
                  output last_of_run, output finished, input ready);
  modport sink   (input valid, input out_position, input out_value, input faces_left,
                  input last_of_run, input finished, output ready);
endinterface

FILE: hdl/jtp_ring.sv
// ----------------------------------------------------------------------------
// jtp_ring: rotating element store
// Holds values and direction marks; rotates one place per shift so the
// element under work always sits at the head, with fixed neighbour taps.
// ----------------------------------------------------------------------------
module jtp_ring (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  jtp_pkg::ring_ctl_t        ctl_i,
  output logic [jtp_pkg::ValW-1:0]  head_val_o,
  output logic                      head_left_o,
  output logic [jtp_pkg::ValW-1:0]  next_val_o,
  output logic [jtp_pkg::ValW-1:0]  tail_val_o
);

  localparam int Depth = jtp_pkg::MaxElements;

  logic [jtp_pkg::ValW-1:0] val_q  [Depth];
  logic [jtp_pkg::ValW-1:0] val_d  [Depth];
  logic                     left_q [Depth];
  logic                     left_d [Depth];

  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      val_d[k]  = val_q[k];
      left_d[k] = left_q[k];
    end
    if (ctl_i.load) begin
      val_d[ctl_i.load_pos]  = ctl_i.load_val;
      left_d[ctl_i.load_pos] = 1'b1;
    end else if (ctl_i.shift) begin
      for (int k = 0; k < Depth - 1; k++) begin
        val_d[k]  = val_q[k+1];
        left_d[k] = left_q[k+1];
      end
      if (ctl_i.swap) begin
        // park the head one step, send its neighbour round first
        val_d[0]        = val_q[0];
        left_d[0]       = left_q[0];
        val_d[Depth-1]  = val_q[1];
        left_d[Depth-1] = left_q[1];
      end else begin
        val_d[Depth-1]  = val_q[0];
        left_d[Depth-1] = left_q[0] ^ ctl_i.flip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) begin
        val_q[k]  <= '0;
        left_q[k] <= 1'b1;
      end
    end else begin
      for (int k = 0; k < Depth; k++) begin
        val_q[k]  <= val_d[k];
        left_q[k] <= left_d[k];
      end
    end
  end

  assign head_val_o  = val_q[0];
  assign head_left_o = left_q[0];
  assign next_val_o  = val_q[1];
  assign tail_val_o  = val_q[Depth-1];

endmodule

FILE: hdl/jtp_eval.sv
// ----------------------------------------------------------------------------
// jtp_eval: shared element compare unit
// Judges the head element once per cycle: whether it is mobile and beats
// the best so far, and whether it is greater than the chosen value.
// ----------------------------------------------------------------------------
module jtp_eval (
  input  logic [jtp_pkg::IdxW-1:0]    idx_i,
  input  logic [jtp_pkg::CountW-1:0]  count_i,
  input  logic [jtp_pkg::ValW-1:0]    cur_val_i,
  input  logic                        cur_left_i,
  input  logic [jtp_pkg::ValW-1:0]    prev_val_i,
  input  logic [jtp_pkg::ValW-1:0]    next_val_i,
  input  logic [jtp_pkg::ValW-1:0]    best_i,
  input  logic                        found_i,
  output logic                        take_o,
  output logic                        above_o
);

  logic [jtp_pkg::CountW-1:0] idx_ext;
  logic                       in_use;
  logic                       mobile;

  assign idx_ext = jtp_pkg::CountW'(idx_i);
  assign in_use  = idx_ext < count_i;
  assign above_o = cur_val_i > best_i;

  always_comb begin
    if (cur_left_i) begin
      mobile = (idx_i != '0) && (cur_val_i > prev_val_i);
    end else begin
      mobile = ((idx_ext + 1'b1) < count_i) && (cur_val_i > next_val_i);
    end
  end

  assign take_o = in_use && mobile && (!found_i || above_o);

endmodule

FILE: hdl/johnson_trotter_permutation_step.sv
// ----------------------------------------------------------------------------
// johnson_trotter_permutation_step: Steinhaus-Johnson-Trotter stepper
// Holds a byte arrangement with direction marks and steps it one
// permutation per advance command.
// ----------------------------------------------------------------------------
// A load writes one element and gives no result. A read rotates the store
// once, one element per cycle unless the output stalls, and emits the first
// count elements (a count of 0 acts as 1, above 16 as 16). An advance makes
// a scan pass to find the mobile element, an update pass to reverse larger
// elements and make the swap (skipped when nothing is mobile), then the emit
// pass. The next command is taken in the cycle after a pass ends. In the
// scan and update passes the rotating store presents one element per cycle
// to the single compare unit. Commands are refused while a pass is running;
// command 3 is dropped.
module johnson_trotter_permutation_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  jtp_in_if.sink                      in_i,
  jtp_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [jtp_pkg::CountW-1:0]  cfg_wdata_i
);

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SScan   = 2'd1;
  localparam logic [1:0] SUpdate = 2'd2;
  localparam logic [1:0] SEmit   = 2'd3;

  localparam logic [jtp_pkg::IdxW-1:0] IdxLast = jtp_pkg::IdxW'(jtp_pkg::MaxElements - 1);

  logic [1:0]                  state_q, state_d;
  logic [jtp_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [jtp_pkg::CountW-1:0]  cnt_q;
  logic [jtp_pkg::CountW-1:0]  count;
  logic [jtp_pkg::ValW-1:0]    best_q, best_d;
  logic [jtp_pkg::IdxW-1:0]    mob_q, mob_d;
  logic [jtp_pkg::IdxW-1:0]    lo_q, lo_d;
  logic                        found_q, found_d;
  logic                        done_q, done_d;

  jtp_pkg::ring_ctl_t          ctl;
  logic [jtp_pkg::ValW-1:0]    head_val;
  logic                        head_left;
  logic [jtp_pkg::ValW-1:0]    next_val;
  logic [jtp_pkg::ValW-1:0]    tail_val;
  logic                        take;
  logic                        above;
  logic                        in_fire;
  logic                        in_use;
  logic                        step;

  always_comb begin
    if (cnt_q == '0) begin
      count = jtp_pkg::CountW'(1);
    end else if (cnt_q > jtp_pkg::CountW'(jtp_pkg::MaxElements)) begin
      count = jtp_pkg::CountW'(jtp_pkg::MaxElements);
    end else begin
      count = cnt_q;
    end
  end

  jtp_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .head_val_o  (head_val),
    .head_left_o (head_left),
    .next_val_o  (next_val),
    .tail_val_o  (tail_val)
  );

  jtp_eval u_eval (
    .idx_i      (idx_q),
    .count_i    (count),
    .cur_val_i  (head_val),
    .cur_left_i (head_left),
    .prev_val_i (tail_val),
    .next_val_i (next_val),
    .best_i     (best_q),
    .found_i    (found_q),
    .take_o     (take),
    .above_o    (above)
  );

  assign in_i.ready = (state_q == SIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_use     = jtp_pkg::CountW'(idx_q) < count;

  assign out_o.valid        = (state_q == SEmit) && in_use;
  assign out_o.out_position = jtp_pkg::PosW'(idx_q);
  assign out_o.out_value    = head_val;
  assign out_o.faces_left   = head_left;
  assign out_o.last_of_run  = (jtp_pkg::CountW'(idx_q) + 1'b1) == count;
  assign out_o.finished     = done_q;

  assign step = !out_o.valid || out_o.ready;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    best_d  = best_q;
    mob_d   = mob_q;
    lo_d    = lo_q;
    found_d = found_q;
    done_d  = done_q;
    ctl     = '0;
    ctl.load_pos = jtp_pkg::IdxW'(in_i.position);
    ctl.load_val = in_i.element_value;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          idx_d = '0;
          unique case (in_i.command)
            jtp_pkg::CmdLoad: begin
              ctl.load = 1'b1;
            end
            jtp_pkg::CmdAdvance: begin
              found_d = 1'b0;
              done_d  = 1'b0;
              best_d  = '0;
              state_d = SScan;
            end
            jtp_pkg::CmdRead: begin
              done_d  = 1'b0;
              state_d = SEmit;
            end
            default: begin
            end
          endcase
        end
      end
      SScan: begin
        ctl.shift = 1'b1;
        idx_d     = idx_q + 1'b1;
        if (take) begin
          found_d = 1'b1;
          best_d  = head_val;
          mob_d   = idx_q;
          lo_d    = head_left ? idx_q - 1'b1 : idx_q;
        end
        if (idx_q == IdxLast) begin
          if (found_d) begin
            state_d = SUpdate;
          end else begin
            done_d  = 1'b1;
            state_d = SEmit;
          end
        end
      end
      SUpdate: begin
        ctl.shift = 1'b1;
        ctl.swap  = (idx_q == lo_q);
        ctl.flip  = above && in_use;
        idx_d     = idx_q + 1'b1;
        if (idx_q == IdxLast) begin
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (step) begin
          ctl.shift = 1'b1;
          idx_d     = idx_q + 1'b1;
          if (idx_q == IdxLast) begin
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      cnt_q   <= jtp_pkg::CountReset;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    mob_q  <= mob_d;
    lo_q   <= lo_d;
  end

  a_idle_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("result offered while idle");

  a_work_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan || state_q == SUpdate) |-> !out_o.valid)
    else $error("result offered during scan or update");

  a_update_needs_mobile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SUpdate |-> found_q)
    else $error("update pass without a mobile element");

  a_done_excludes_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !found_q)
    else $error("finished flag raised with a mobile element found");

  a_swap_at_mobile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SUpdate && idx_q == lo_q) |-> (lo_q == mob_q || lo_q + 1'b1 == mob_q))
    else $error("swap position not next to the mobile element");

endmodule

FILE: tb/sv/tb_johnson_trotter_permutation_step.sv
// ----------------------------------------------------------------------------
// tb_johnson_trotter_permutation_step: self-checking bench for the stepper
// Drives load, advance and read commands through the valid/ready command
// channel and checks every emitted element word, field by field, against
// a cycle-free model of the arrangement kept in the bench. Directed cases
// come first, then random tours of the permutation under random stalls.
// ----------------------------------------------------------------------------
module tb_johnson_trotter_permutation_step;

  localparam logic [jtp_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int SettleCycles = 64;
  localparam int DrainLimit   = 20000;
  localparam int CycleLimit   = 600000;
  localparam int LongHold     = 400;
  localparam int RandomItems  = 255;

  typedef struct {
    logic [jtp_pkg::PosW-1:0] position;
    logic [jtp_pkg::ValW-1:0] value;
    logic                     left;
    logic                     is_last;
    logic                     done;
  } elem_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                       cfg_we_i;
  logic [jtp_pkg::CountW-1:0] cfg_wdata_i;

  jtp_in_if  in_if ();
  jtp_out_if out_if ();

  johnson_trotter_permutation_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [jtp_pkg::ValW-1:0]   ring_val  [jtp_pkg::MaxElements];
  logic                       ring_left [jtp_pkg::MaxElements];
  logic [jtp_pkg::CountW-1:0] count_setting;
  elem_word_t                 pending_elements [$];

  int error_count  = 0;
  int cycle_count  = 0;
  bit src_idle_on  = 1'b0;
  bit snk_idle_on  = 1'b0;
  int snk_hold_req = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // model of the arrangement

  function automatic void reset_arrangement();
    for (int i = 0; i < jtp_pkg::MaxElements; i++) begin
      ring_val[i]  = '0;
      ring_left[i] = 1'b1;
    end
    count_setting = jtp_pkg::CountReset;
  endfunction

  function automatic int elements_in_use();
    if (count_setting == 0) return 1;
    if (count_setting > jtp_pkg::MaxElements) return jtp_pkg::MaxElements;
    return int'(count_setting);
  endfunction

  function automatic bit step_permutation(input int n);
    bit                       found;
    bit                       mobile;
    int                       mob;
    int                       other;
    logic [jtp_pkg::ValW-1:0] best;
    logic [jtp_pkg::ValW-1:0] tv;
    logic                     td;
    found = 1'b0;
    mob   = 0;
    best  = '0;
    for (int i = 0; i < n; i++) begin
      mobile = 1'b0;
      if (ring_left[i]) begin
        if (i > 0) mobile = ring_val[i] > ring_val[i-1];
      end else begin
        if (i + 1 < n) mobile = ring_val[i] > ring_val[i+1];
      end
      if (mobile && (!found || ring_val[i] > best)) begin
        found = 1'b1;
        best  = ring_val[i];
        mob   = i;
      end
    end
    if (!found) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (ring_val[i] > best) ring_left[i] = !ring_left[i];
    end
    other = ring_left[mob] ? mob - 1 : mob + 1;
    tv = ring_val[mob];
    ring_val[mob] = ring_val[other];
    ring_val[other] = tv;
    td = ring_left[mob];
    ring_left[mob] = ring_left[other];
    ring_left[other] = td;
    return 1'b1;
  endfunction

  function automatic void push_arrangement(input int n, input bit done);
    elem_word_t w;
    for (int i = 0; i < n; i++) begin
      w.position = jtp_pkg::PosW'(i);
      w.value    = ring_val[i];
      w.left     = ring_left[i];
      w.is_last  = (i == n - 1);
      w.done     = done;
      pending_elements.push_back(w);
    end
  endfunction

  function automatic void predict_command(input logic [jtp_pkg::CmdW-1:0] cmd,
                                          input logic [jtp_pkg::PosW-1:0] pos,
                                          input logic [jtp_pkg::ValW-1:0] val);
    int n;
    bit moved;
    n = elements_in_use();
    case (cmd)
      jtp_pkg::CmdLoad: begin
        ring_val[pos]  = val;
        ring_left[pos] = 1'b1;
      end
      jtp_pkg::CmdAdvance: begin
        moved = step_permutation(n);
        push_arrangement(n, !moved);
      end
      jtp_pkg::CmdRead: push_arrangement(n, 1'b0);
      default: ;
    endcase
  endfunction

  // command side

  task automatic send_word(input logic [jtp_pkg::CmdW-1:0] cmd,
                           input logic [jtp_pkg::PosW-1:0] pos,
                           input logic [jtp_pkg::ValW-1:0] val);
    int gap;
    gap = src_idle_on ? $urandom_range(9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.command       <= cmd;
    in_if.position      <= pos;
    in_if.element_value <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_command(cmd, pos, val);
  endtask

  task automatic settle_block();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_elements.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_elements.size() != 0) begin
      report_mismatch($sformatf("%0d element words never arrived", pending_elements.size()));
      pending_elements.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [jtp_pkg::CountW-1:0] cnt);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_setting = cnt;
    @(posedge clk_i);
  endtask

  // result side

  initial begin
    int w;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (snk_hold_req > 0) begin
        out_if.ready <= 1'b0;
        repeat (snk_hold_req) @(posedge clk_i);
        snk_hold_req = 0;
      end
      w = snk_idle_on ? $urandom_range(9) : 0;
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) begin
        if (snk_hold_req > 0) break;
        @(posedge clk_i);
      end
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  elem_word_t seen_word;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected element word at position %0d",
                                  out_if.out_position));
      end else begin
        seen_word = pending_elements.pop_front();
        compare_field("out_position", int'(seen_word.position), int'(out_if.out_position));
        compare_field("out_value", int'(seen_word.value), int'(out_if.out_value));
        compare_field("faces_left", int'(seen_word.left), int'(out_if.faces_left));
        compare_field("last_of_run", int'(seen_word.is_last), int'(out_if.last_of_run));
        compare_field("finished", int'(seen_word.done), int'(out_if.finished));
      end
    end
  end

  // tests

  task automatic test_reset_state();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    send_word(jtp_pkg::CmdRead, 4'd0, 8'd0);
    send_word(jtp_pkg::CmdAdvance, 4'd15, 8'd255);
    settle_block();
  endtask

  task automatic test_count_extremes();
    write_count(5'd0);
    send_word(jtp_pkg::CmdRead, 4'd0, 8'd0);
    settle_block();
    write_count(5'd31);
    send_word(jtp_pkg::CmdRead, 4'd0, 8'd0);
    settle_block();
    write_count(5'd17);
    send_word(jtp_pkg::CmdAdvance, 4'd0, 8'd0);
    settle_block();
  endtask

  task automatic test_three_element_tour();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    write_count(5'd3);
    for (int i = 0; i < 3; i++) begin
      send_word(jtp_pkg::CmdLoad, jtp_pkg::PosW'(i), jtp_pkg::ValW'(i + 1));
    end
    repeat (6) send_word(jtp_pkg::CmdAdvance, 4'd0, 8'd0);
    settle_block();
  endtask

  task automatic test_corner_words();
    send_word(jtp_pkg::CmdLoad, 4'd0, 8'd0);
    send_word(jtp_pkg::CmdLoad, 4'd1, 8'd255);
    send_word(jtp_pkg::CmdLoad, 4'd2, 8'd255);
    send_word(jtp_pkg::CmdAdvance, 4'd0, 8'd0);
    send_word(jtp_pkg::CmdAdvance, 4'd0, 8'd0);
    send_word(CmdUnused, 4'd15, 8'd255);
    send_word(jtp_pkg::CmdLoad, 4'd15, 8'hA5);
    settle_block();
    write_count(5'd16);
    send_word(jtp_pkg::CmdRead, 4'd0, 8'd0);
    settle_block();
  endtask

  task automatic test_output_stall();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    snk_hold_req = LongHold;
    repeat (6) begin
      send_word(jtp_pkg::CmdAdvance, jtp_pkg::PosW'($urandom_range(15)),
                jtp_pkg::ValW'($urandom_range(255)));
    end
    settle_block();
  endtask

  task automatic test_paced_commands();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    write_count(5'd4);
    for (int i = 0; i < 4; i++) begin
      send_word(jtp_pkg::CmdLoad, jtp_pkg::PosW'(i), jtp_pkg::ValW'($urandom_range(255)));
    end
    repeat (4) begin
      send_word(jtp_pkg::CmdAdvance, 4'd0, 8'd0);
      settle_block();
    end
  endtask

  task automatic test_random_tours(input int budget);
    int sent;
    int r;
    int cnt;
    int n;
    int run;
    int j;
    int tmp;
    int slot [jtp_pkg::MaxElements];
    logic [jtp_pkg::ValW-1:0] vals [jtp_pkg::MaxElements];
    bit used [256];
    bit distinct;
    sent = 0;
    while (sent < budget) begin
      src_idle_on = $urandom_range(3) != 0;
      snk_idle_on = $urandom_range(3) != 0;
      r = $urandom_range(19);
      if (r < 14) cnt = $urandom_range(5, 2);
      else if (r < 16) cnt = 1;
      else if (r == 16) cnt = 16;
      else if (r == 17) cnt = 0;
      else cnt = $urandom_range(31, 17);
      write_count(jtp_pkg::CountW'(cnt));
      n = elements_in_use();
      distinct = $urandom_range(3) != 0;
      for (int v = 0; v < 256; v++) used[v] = 1'b0;
      for (int i = 0; i < n; i++) begin
        slot[i] = i;
        if (distinct) begin
          do vals[i] = jtp_pkg::ValW'($urandom_range(255)); while (used[vals[i]]);
          used[vals[i]] = 1'b1;
        end else begin
          vals[i] = jtp_pkg::ValW'($urandom_range(2));
        end
      end
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = slot[i];
        slot[i] = slot[j];
        slot[j] = tmp;
      end
      for (int i = 0; i < n; i++) begin
        send_word(jtp_pkg::CmdLoad, jtp_pkg::PosW'(slot[i]), vals[slot[i]]);
        sent++;
      end
      run = (n <= 4) ? $urandom_range(26, 5) : $urandom_range(12, 3);
      for (int k = 0; k < run; k++) begin
        r = $urandom_range(19);
        if (r < 15) begin
          send_word(jtp_pkg::CmdAdvance, jtp_pkg::PosW'($urandom_range(15)),
                    jtp_pkg::ValW'($urandom_range(255)));
        end else if (r < 17) begin
          send_word(jtp_pkg::CmdRead, jtp_pkg::PosW'($urandom_range(15)),
                    jtp_pkg::ValW'($urandom_range(255)));
        end else if (r < 18) begin
          send_word(CmdUnused, jtp_pkg::PosW'($urandom_range(15)),
                    jtp_pkg::ValW'($urandom_range(255)));
        end else begin
          send_word(jtp_pkg::CmdLoad, jtp_pkg::PosW'($urandom_range(15)),
                    jtp_pkg::ValW'($urandom_range(255)));
        end
        sent++;
      end
      settle_block();
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.command       <= jtp_pkg::CmdLoad;
    in_if.position      <= '0;
    in_if.element_value <= '0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    reset_arrangement();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_count_extremes();
    test_three_element_tour();
    test_corner_words();
    test_output_stall();
    test_paced_commands();
    test_random_tours(RandomItems);

    settle_block();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: johnson_trotter_permutation_step.f
hdl/jtp_pkg.sv
hdl/jtp_if.sv
hdl/jtp_ring.sv
hdl/jtp_eval.sv
hdl/johnson_trotter_permutation_step.sv
tb/sv/tb_johnson_trotter_permutation_step.sv
